>>> hdl/cacf_pkg.sv
// Shared types, codes and constants for the CAN address-claim controller.
`timescale 1ns / 1ps
`default_nettype none
package cacf_pkg;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 64;

  localparam logic [7:0] AddrNull = 8'd254;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegDynamicMode   = 4'd0;
  localparam logic [CfgIdxW-1:0] RegStaticAddress = 4'd1;
  localparam logic [CfgIdxW-1:0] RegOwnName       = 4'd2;
  localparam logic [CfgIdxW-1:0] RegVerifyTimeout = 4'd3;
  localparam logic [CfgIdxW-1:0] RegRangeStart    = 4'd4;
  localparam logic [CfgIdxW-1:0] RegRangeEnd      = 4'd5;
  localparam logic [CfgIdxW-1:0] RegClaimDgn      = 4'd6;
  localparam logic [CfgIdxW-1:0] RegClaimPriority = 4'd7;

  // Request codes
  localparam logic [1:0] ReqStart = 2'd0;
  localparam logic [1:0] ReqTick  = 2'd1;
  localparam logic [1:0] ReqRx    = 2'd2;

  typedef enum logic [2:0] {
    ST_INIT        = 3'd0,
    ST_WAIT_CLAIM  = 3'd1,
    ST_WAIT_VERIFY = 3'd2,
    ST_CLAIMED     = 3'd3,
    ST_CANNOT      = 3'd4
  } state_e;

  typedef struct packed {
    logic        dynamic_mode;
    logic [7:0]  static_address;
    logic [63:0] own_name;
    logic [15:0] verify_timeout_ms;
    logic [7:0]  range_start;
    logic [7:0]  range_end;
    logic [16:0] claim_dgn;
    logic [2:0]  claim_priority;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] now_ms;
    logic [28:0] rx_can_id;
    logic [63:0] rx_name;
  } in_t;

  typedef struct packed {
    logic        claim_valid;
    logic [28:0] claim_can_id;
    logic [63:0] claim_payload;
    logic [2:0]  claim_state;
    logic [7:0]  cur_address;
    logic [7:0]  confirmed_address;
    logic        is_claimed;
  } out_t;

endpackage
`default_nettype wire

>>> hdl/cacf_cfg_regs.sv
// Configuration register file of the address-claim controller.
`timescale 1ns / 1ps
`default_nettype none
module cacf_cfg_regs
  import cacf_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dynamic_mode      <= 1'b0;
      cfg_q.static_address    <= 8'd128;
      cfg_q.own_name          <= 64'd0;
      cfg_q.verify_timeout_ms <= 16'd250;
      cfg_q.range_start       <= 8'd143;
      cfg_q.range_end         <= 8'd128;
      cfg_q.claim_dgn         <= 17'd60928;
      cfg_q.claim_priority    <= 3'd6;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegDynamicMode:   cfg_q.dynamic_mode      <= cfg_wdata_i[0];
        RegStaticAddress: cfg_q.static_address    <= cfg_wdata_i[7:0];
        RegOwnName:       cfg_q.own_name          <= cfg_wdata_i;
        RegVerifyTimeout: cfg_q.verify_timeout_ms <= cfg_wdata_i[15:0];
        RegRangeStart:    cfg_q.range_start       <= cfg_wdata_i[7:0];
        RegRangeEnd:      cfg_q.range_end         <= cfg_wdata_i[7:0];
        RegClaimDgn:      cfg_q.claim_dgn         <= cfg_wdata_i[16:0];
        RegClaimPriority: cfg_q.claim_priority    <= cfg_wdata_i[2:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

>>> hdl/cacf_core.sv
// Claim state machine: state registers, next-state logic and result assembly.
`timescale 1ns / 1ps
`default_nettype none
module cacf_core
  import cacf_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic evt_fire_i,
  input  in_t       evt_i,
  input  cfg_t      cfg_i,
  output out_t      res_o
);

  state_e      state_q, state_d;
  logic [7:0]  cur_q, cur_d;
  logic [7:0]  held_q, held_d;
  logic [31:0] time_q, time_d;
  logic        emit;

  logic [16:0] rx_grp;
  logic [7:0]  rx_sa;
  logic        active;
  logic        conflict;
  logic [31:0] elapsed;

  assign rx_grp   = evt_i.rx_can_id[24:8];
  assign rx_sa    = evt_i.rx_can_id[7:0];
  assign active   = (state_q == ST_WAIT_CLAIM) || (state_q == ST_WAIT_VERIFY) ||
                    (state_q == ST_CLAIMED);
  assign conflict = active && (rx_grp == cfg_i.claim_dgn) &&
                    (evt_i.rx_name != cfg_i.own_name) && (rx_sa == cur_q);
  assign elapsed  = evt_i.now_ms - time_q;

  // Next state
  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    held_d  = held_q;
    time_d  = time_q;
    emit    = 1'b0;
    case (evt_i.req_type)
      ReqStart: begin
        if (!cfg_i.dynamic_mode) begin
          state_d = ST_WAIT_CLAIM;
          cur_d   = cfg_i.static_address;
          emit    = 1'b1;
        end else if (cfg_i.range_start >= cfg_i.range_end) begin
          state_d = ST_WAIT_CLAIM;
          cur_d   = cfg_i.range_start;
          emit    = 1'b1;
        end else begin
          state_d = ST_CANNOT;
          cur_d   = AddrNull;
        end
      end
      ReqTick: begin
        if (state_q == ST_WAIT_CLAIM) begin
          state_d = ST_WAIT_VERIFY;
          time_d  = evt_i.now_ms;
        end else if (state_q == ST_WAIT_VERIFY &&
                     elapsed >= {16'd0, cfg_i.verify_timeout_ms}) begin
          state_d = ST_CLAIMED;
          held_d  = cur_q;
        end
      end
      ReqRx: begin
        if (conflict) begin
          if (cfg_i.own_name < evt_i.rx_name) begin
            emit = 1'b1;
          end else if (cfg_i.dynamic_mode && cur_q > cfg_i.range_end) begin
            state_d = ST_WAIT_CLAIM;
            cur_d   = cur_q - 8'd1;
            emit    = 1'b1;
          end else begin
            state_d = ST_CANNOT;
            cur_d   = AddrNull;
          end
        end
      end
      default: ;  // unknown request: report status only
    endcase
  end

  // Result of this transaction, built from the updated state
  always_comb begin
    res_o.claim_valid       = emit;
    res_o.claim_can_id      = emit ? {cfg_i.claim_priority, 1'b0, cfg_i.claim_dgn, cur_d}
                                   : 29'd0;
    res_o.claim_payload     = emit ? cfg_i.own_name : 64'd0;
    res_o.claim_state       = state_d;
    res_o.cur_address       = cur_d;
    res_o.confirmed_address = held_d;
    res_o.is_claimed        = (state_d == ST_CLAIMED);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      cur_q   <= AddrNull;
      held_q  <= AddrNull;
      time_q  <= 32'd0;
    end else if (evt_fire_i) begin
      state_q <= state_d;
      cur_q   <= cur_d;
      held_q  <= held_d;
      time_q  <= time_d;
    end
  end

`ifndef SYNTHESIS
  a_claimed_holds_cur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLAIMED |-> held_q == cur_q)
    else $error("claimed state with confirmed address not equal to current");
  a_cannot_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CANNOT |-> cur_q == AddrNull)
    else $error("cannot-claim state with an address held");
  a_init_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_INIT |-> (cur_q == AddrNull && held_q == AddrNull))
    else $error("init state with an address set");
`endif

endmodule
`default_nettype wire

>>> hdl/can_address_claim_fsm_top.sv
// Top level of the CAN address-claim controller: input stage, core, result register.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------
//  in      | input     | in_valid_i / in_ready_o    | in_data_i  (in_t)
//  out     | output    | out_valid_o / out_ready_i  | out_data_o (out_t)
//  cfg     | input     | cfg_we_i (no wait)         | cfg_index_i, cfg_wdata_i
//
// Each event transaction is evaluated against the claim state while it sits
// in the input register and lands in the result register at the next edge;
// one transaction per cycle sustained while results are taken.
// Reset (rst_ni low, asynchronous) empties both stages, puts the claim state
// in init with null addresses and loads the register defaults.
// A stalled result holds the result register; a buffered event then holds in
// the input register and in_ready_o drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
module can_address_claim_fsm_top
  import cacf_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  in_t                      in_data_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output out_t                     out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t cfg;
  out_t res;

  logic in_vld_q;
  in_t  in_q;
  logic out_vld_q;
  out_t out_q;
  logic res_free;
  logic evt_fire;

  // The result register can take a new result when empty or being drained.
  assign res_free   = !out_vld_q || out_ready_i;
  // Evaluate the buffered event when its result has a place to go.
  assign evt_fire   = in_vld_q && res_free;
  assign in_ready_o = !in_vld_q || res_free;

  cacf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  cacf_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .evt_fire_i (evt_fire),
    .evt_i      (in_q),
    .cfg_i      (cfg),
    .res_o      (res)
  );

  // Input stage: hold the event until the core evaluates it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // Result stage: advance on evaluation, drop on acceptance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_free) begin
      out_vld_q <= evt_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while both stages are full and stalled");
  a_claimed_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.is_claimed == (out_q.claim_state == ST_CLAIMED)))
    else $error("is_claimed disagrees with claim_state");
  a_no_claim_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.claim_valid) |->
      (out_q.claim_can_id == 29'd0 && out_q.claim_payload == 64'd0))
    else $error("claim frame fields set without a claim");
`endif

endmodule
`default_nettype wire
